// ----- hw/rtl/serial_command_frame_handler_defines.svh -----
// assertion macros for the serial command frame handler
// used by serial_command_frame_handler.sv; expects clk and arst_n in scope
`ifndef SERIAL_COMMAND_FRAME_HANDLER_DEFINES_SVH
`define SERIAL_COMMAND_FRAME_HANDLER_DEFINES_SVH

// same-cycle implication, off during reset
`define SCFH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define SCFH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/scfh_pkg.sv -----
// types, codes and helper functions for the serial command frame handler
// no dependencies
package scfh_pkg;

	localparam int FRAME_BYTES_DEF = 10;
	localparam int CNT_W           = 4;
	localparam int EM_BYTES        = 11;
	localparam int EM_IDX_W        = 4;

	localparam logic [7:0] ACK_BYTE = 8'd123;

	// frame type bytes
	localparam logic [7:0] TYPE_RUN    = 8'd82;
	localparam logic [7:0] TYPE_SOFT   = 8'd80;
	localparam logic [7:0] TYPE_HARD   = 8'd70;
	localparam logic [7:0] TYPE_GAINS  = 8'd67;
	localparam logic [7:0] TYPE_STOP   = 8'd83;
	localparam logic [7:0] TYPE_STATUS = 8'd68;

	// parameter ids
	localparam logic [3:0] P_IREF  = 4'd0;
	localparam logic [3:0] P_DUTY  = 4'd1;
	localparam logic [3:0] P_FREQ  = 4'd2;
	localparam logic [3:0] P_SOFT0 = 4'd3;
	localparam logic [3:0] P_SOFT1 = 4'd4;
	localparam logic [3:0] P_SOFT2 = 4'd5;
	localparam logic [3:0] P_SOFT3 = 4'd6;
	localparam logic [3:0] P_HARD0 = 4'd7;
	localparam logic [3:0] P_HARD1 = 4'd8;
	localparam logic [3:0] P_KP    = 4'd9;
	localparam logic [3:0] P_KI    = 4'd10;
	localparam logic [3:0] P_VREF  = 4'd11;
	localparam logic [3:0] P_START = 4'd12;
	localparam logic [3:0] P_STOP  = 4'd13;
	localparam logic [3:0] P_MAX   = 4'd13;

	typedef enum logic [2:0] {
		FK_STATUS,
		FK_RUN,
		FK_SOFT,
		FK_HARD,
		FK_GAINS,
		FK_STOP
	} frame_kind_t;

	// frame length in bytes, zero for an unknown type
	function automatic logic [CNT_W-1:0] frame_len(input logic [7:0] t);
		logic [CNT_W-1:0] n;
		case (t)
			TYPE_RUN:    n = CNT_W'(9);
			TYPE_SOFT:   n = CNT_W'(10);
			TYPE_HARD:   n = CNT_W'(7);
			TYPE_GAINS:  n = CNT_W'(7);
			TYPE_STOP:   n = CNT_W'(3);
			TYPE_STATUS: n = CNT_W'(1);
			default:     n = '0;
		endcase
		return n;
	endfunction

	function automatic frame_kind_t frame_kind(input logic [7:0] t);
		frame_kind_t k;
		case (t)
			TYPE_RUN:    k = FK_RUN;
			TYPE_SOFT:   k = FK_SOFT;
			TYPE_HARD:   k = FK_HARD;
			TYPE_GAINS:  k = FK_GAINS;
			TYPE_STATUS: k = FK_STATUS;
			default:     k = FK_STOP;
		endcase
		return k;
	endfunction

	// index of the final word sent for a frame kind
	function automatic logic [EM_IDX_W-1:0] last_idx(input frame_kind_t k);
		logic [EM_IDX_W-1:0] n;
		case (k)
			FK_STATUS: n = EM_IDX_W'(10);
			FK_HARD:   n = EM_IDX_W'(2);
			FK_GAINS:  n = EM_IDX_W'(2);
			default:   n = EM_IDX_W'(4);
		endcase
		return n;
	endfunction

endpackage

// ----- hw/rtl/serial_command_frame_handler.sv -----
// serial command frame handler top level: frame gathering, trailer check and word sequencer
// depends on scfh_pkg and serial_command_frame_handler_defines.svh
`include "serial_command_frame_handler_defines.svh"

// Takes one word per cycle: a received serial byte (cmd 0) or a status latch (cmd 1).
// Each word is held in an input register, where the frame state, the running sum and the
// trailer check are updated. A completed good frame loads a sequencer that drives one
// output word per cycle, unless out_stall holds it, into the output register: 3 to 5
// words for a command frame (parameter writes, then ack 123), 11 for a status reply. The
// closing byte goes through the input register and the sequencer before the first output
// word reaches the output register. Input words that produce no output never wait; the
// input stalls only when a frame completes while the sequencer still has words of the
// previous frame to send, so the sequencer and the output stall set the throughput then.
module serial_command_frame_handler #(
	parameter int FRAME_BYTES = scfh_pkg::FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] vin_display,
	input  logic [15:0] vout_display,
	input  logic [15:0] iout_display,
	input  logic [7:0]  temp_display,
	input  logic [7:0]  prot_status_hi,
	input  logic [7:0]  prot_status_lo,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  tx_byte,
	output logic [3:0]  param_id,
	output logic [15:0] param_value,
	output logic        last
);

	localparam int IdxW = $clog2(FRAME_BYTES);
	localparam logic [scfh_pkg::CNT_W:0] FbLim = (scfh_pkg::CNT_W + 1)'(FRAME_BYTES);

	// input register
	logic        s1_vld_q;
	logic        cmd_s1;
	logic [7:0]  rx_byte_s1;
	logic [15:0] vin_s1, vout_s1, iout_s1;
	logic [7:0]  temp_s1, prot_hi_s1, prot_lo_s1;

	// frame state
	logic [7:0]                  fbuf_q [FRAME_BYTES];
	logic [scfh_pkg::CNT_W-1:0]  byte_count_q;
	logic [15:0]                 running_sum_q;
	logic [7:0]                  prev_q;
	logic [15:0]                 vin_q, vout_q, iout_q, status_q;
	logic [7:0]                  temp_q;

	// sequencer
	logic                          em_busy_q;
	scfh_pkg::frame_kind_t         em_kind_q;
	logic [scfh_pkg::EM_IDX_W-1:0] em_idx_q;
	logic [7:0]                    em_buf_q [scfh_pkg::EM_BYTES];

	// output register
	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  tx_byte_q;
	logic [3:0]  param_id_q;
	logic [15:0] param_value_q;
	logic        last_q;

	// frame step logic
	logic [scfh_pkg::CNT_W-1:0] pos, len;
	logic [scfh_pkg::CNT_W:0]   pos_nx;
	logic [7:0]                 ftype;
	logic                       ignore, drop, store, complete, emits;
	logic [15:0]                sum_base, sum_nx, stat_sum;
	logic [7:0]                 stat_bytes [9];
	logic [7:0]                 em_load [scfh_pkg::EM_BYTES];

	logic out_free, em_last, em_free, s1_go, s1_fire, in_acc;

	always_comb begin
		pos    = byte_count_q;
		ftype  = (pos == '0) ? rx_byte_s1 : fbuf_q[0];
		len    = scfh_pkg::frame_len(ftype);
		pos_nx = {1'b0, pos} + 1'b1;
		ignore = (pos == '0) && (len == '0);
		drop   = !ignore && ((len == '0) || (pos >= len) || ({1'b0, pos} >= FbLim));
		store  = !ignore && !drop;
		sum_base = (pos == '0) ? 16'd0 : running_sum_q;
		if ((len > scfh_pkg::CNT_W'(1)) && (pos < len - scfh_pkg::CNT_W'(2))) begin
			sum_nx = sum_base + {8'd0, rx_byte_s1};
		end else begin
			sum_nx = sum_base;
		end
		complete = store && (pos_nx >= {1'b0, len});
		// closing byte is the trailer low byte; high byte was the previous one
		emits = complete && ((ftype == scfh_pkg::TYPE_STATUS) ||
			({prev_q, rx_byte_s1} == sum_base));
	end

	always_comb begin
		stat_bytes[0] = vin_q[15:8];
		stat_bytes[1] = vin_q[7:0];
		stat_bytes[2] = vout_q[15:8];
		stat_bytes[3] = vout_q[7:0];
		stat_bytes[4] = iout_q[15:8];
		stat_bytes[5] = iout_q[7:0];
		stat_bytes[6] = temp_q;
		stat_bytes[7] = status_q[15:8];
		stat_bytes[8] = status_q[7:0];
		stat_sum = '0;
		for (int i = 0; i < 9; i++) begin
			stat_sum = stat_sum + {8'd0, stat_bytes[i]};
		end
		for (int i = 0; i < scfh_pkg::EM_BYTES; i++) begin
			em_load[i] = '0;
		end
		if (ftype == scfh_pkg::TYPE_STATUS) begin
			for (int i = 0; i < 9; i++) begin
				em_load[i] = stat_bytes[i];
			end
			em_load[9]  = stat_sum[15:8];
			em_load[10] = stat_sum[7:0];
		end else begin
			// payload bytes are all in the buffer before the closing byte arrives
			for (int i = 1; i < 8; i++) begin
				em_load[i] = fbuf_q[i];
			end
		end
	end

	// handshake
	assign out_free = !out_valid_q || !out_stall;
	assign em_last  = (em_idx_q == scfh_pkg::last_idx(em_kind_q));
	assign em_free  = !em_busy_q || (out_free && em_last);
	assign s1_go    = !emits || cmd_s1 || em_free;
	assign s1_fire  = s1_vld_q && s1_go;
	assign in_stall = s1_vld_q && !s1_go;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (in_acc) begin
			s1_vld_q <= 1'b1;
		end else if (s1_fire) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1     <= cmd;
			rx_byte_s1 <= rx_byte;
			vin_s1     <= vin_display;
			vout_s1    <= vout_display;
			iout_s1    <= iout_display;
			temp_s1    <= temp_display;
			prot_hi_s1 <= prot_status_hi;
			prot_lo_s1 <= prot_status_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			running_sum_q <= '0;
			vin_q         <= '0;
			vout_q        <= '0;
			iout_q        <= '0;
			temp_q        <= '0;
			status_q      <= '0;
		end else if (s1_fire) begin
			if (cmd_s1) begin
				vin_q    <= vin_s1;
				vout_q   <= vout_s1;
				iout_q   <= iout_s1;
				temp_q   <= temp_s1;
				status_q <= {prot_hi_s1, prot_lo_s1};
			end else if (drop) begin
				byte_count_q <= '0;
			end else if (store) begin
				running_sum_q <= sum_nx;
				byte_count_q  <= complete ? '0 : pos_nx[scfh_pkg::CNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && !cmd_s1 && store) begin
			fbuf_q[pos[IdxW-1:0]] <= rx_byte_s1;
			prev_q                <= rx_byte_s1;
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_busy_q <= 1'b0;
			em_idx_q  <= '0;
		end else if (s1_fire && !cmd_s1 && emits) begin
			em_busy_q <= 1'b1;
			em_idx_q  <= '0;
		end else if (em_busy_q && out_free) begin
			if (em_last) begin
				em_busy_q <= 1'b0;
			end
			em_idx_q <= em_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && !cmd_s1 && emits) begin
			em_kind_q <= scfh_pkg::frame_kind(ftype);
			for (int i = 0; i < scfh_pkg::EM_BYTES; i++) begin
				em_buf_q[i] <= em_load[i];
			end
		end
	end

	// word for the current sequencer index
	localparam logic [scfh_pkg::EM_IDX_W-1:0] EM_I0 = scfh_pkg::EM_IDX_W'(0);
	localparam logic [scfh_pkg::EM_IDX_W-1:0] EM_I1 = scfh_pkg::EM_IDX_W'(1);
	localparam logic [scfh_pkg::EM_IDX_W-1:0] EM_I2 = scfh_pkg::EM_IDX_W'(2);

	logic        r_kind;
	logic [7:0]  r_tx;
	logic [3:0]  r_id;
	logic [15:0] r_val;
	logic [15:0] w1, w3, w5;

	assign w1 = {em_buf_q[1], em_buf_q[2]};
	assign w3 = {em_buf_q[3], em_buf_q[4]};
	assign w5 = {em_buf_q[5], em_buf_q[6]};

	always_comb begin
		r_kind = 1'b1;
		r_tx   = '0;
		r_id   = '0;
		r_val  = '0;
		if (em_kind_q == scfh_pkg::FK_STATUS) begin
			r_kind = 1'b0;
			r_tx   = em_buf_q[em_idx_q];
		end else if (em_last) begin
			r_kind = 1'b0;
			r_tx   = scfh_pkg::ACK_BYTE;
		end else begin
			case (em_kind_q)
				scfh_pkg::FK_RUN: begin
					case (em_idx_q)
						EM_I0:   begin r_id = scfh_pkg::P_START; r_val = 16'd1; end
						EM_I1:   begin r_id = scfh_pkg::P_IREF;  r_val = w1; end
						EM_I2:   begin r_id = scfh_pkg::P_DUTY;  r_val = w3; end
						default: begin r_id = scfh_pkg::P_FREQ;  r_val = w5; end
					endcase
				end
				scfh_pkg::FK_SOFT: begin
					case (em_idx_q)
						EM_I0:   begin r_id = scfh_pkg::P_SOFT0; r_val = w1; end
						EM_I1:   begin r_id = scfh_pkg::P_SOFT1; r_val = w3; end
						EM_I2:   begin r_id = scfh_pkg::P_SOFT2; r_val = w5; end
						default: begin r_id = scfh_pkg::P_SOFT3; r_val = {8'd0, em_buf_q[7]}; end
					endcase
				end
				scfh_pkg::FK_HARD: begin
					case (em_idx_q)
						EM_I0:   begin r_id = scfh_pkg::P_HARD0; r_val = w1; end
						default: begin r_id = scfh_pkg::P_HARD1; r_val = w3; end
					endcase
				end
				scfh_pkg::FK_GAINS: begin
					case (em_idx_q)
						EM_I0:   begin r_id = scfh_pkg::P_KP; r_val = w1; end
						default: begin r_id = scfh_pkg::P_KI; r_val = w3; end
					endcase
				end
				default: begin
					// shutdown: stop flag, then references cleared
					case (em_idx_q)
						EM_I0:   begin r_id = scfh_pkg::P_STOP; r_val = 16'd1; end
						EM_I1:   r_id = scfh_pkg::P_IREF;
						EM_I2:   r_id = scfh_pkg::P_VREF;
						default: r_id = scfh_pkg::P_FREQ;
					endcase
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (em_busy_q && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (em_busy_q && out_free) begin
			kind_q        <= r_kind;
			tx_byte_q     <= r_tx;
			param_id_q    <= r_id;
			param_value_q <= r_val;
			last_q        <= em_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign tx_byte     = tx_byte_q;
	assign param_id    = param_id_q;
	assign param_value = param_value_q;
	assign last        = last_q;

	`SCFH_ASSERT_NOW(a_param_word_clean, out_valid_q && kind_q, (tx_byte_q == 8'd0) && (param_id_q <= scfh_pkg::P_MAX), "parameter word carries a byte or a bad id")
	`SCFH_ASSERT_NOW(a_count_in_frame, 1'b1, byte_count_q <= scfh_pkg::CNT_W'(FRAME_BYTES - 1), "byte count beyond longest frame")
	`SCFH_ASSERT_NEXT(a_seq_holds, em_busy_q && !out_free && !(s1_fire && !cmd_s1 && emits), $stable(em_idx_q) && em_busy_q, "sequencer moved while output stalled")

endmodule
